// ----- rtl/tpd_pkg.sv -----
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and codes for the three-point derivative block: result
// status codes and the bit positions of the pending-slope mask.
// ----------------------------------------------------------------------------
package tpd_pkg;

  // Result status
  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UNORDERED = 2'd1;
  localparam status_t ST_SHORT     = 2'd2;
  localparam status_t ST_SAT       = 2'd3;

  // Pending slope jobs, served lowest bit first
  localparam int JOB_W       = 3;
  localparam int JOB_FIRST   = 0;
  localparam int JOB_CENTRAL = 1;
  localparam int JOB_END     = 2;

  typedef logic [JOB_W-1:0] job_mask_t;

endpackage

// ----- rtl/three_point_derivative.sv -----
// ----------------------------------------------------------------------------
// three_point_derivative
// A slope word passes S_NUM, S_SUM, S_ABS, S_CHK, S_DIV and S_FIN, then the
// result and output registers; a status-only word goes from its sample to the
// result and output registers. Samples with no word are taken one per cycle;
// a word holds off new samples until handed on. Each slope uses the bit-serial
// restoring divider (one quotient bit per cycle) unless S_CHK saturates it
// early. An output stall holds the finished word. Reset clears the window,
// fill count, discard flag and all handshake state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module three_point_derivative #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] sample_x_i,
  input  logic signed [DATA_WIDTH-1:0] sample_y_i,
  input  logic                         run_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] slope_o,
  output tpd_pkg::status_t             status_o,
  output logic                         final_result_o
);
  import tpd_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int NW   = DATA_WIDTH + 3;             // numerator width
  localparam int MTW  = NW + FRAC_BITS;             // scaled dividend width
  localparam int HW   = FRAC_BITS + 2;              // dividend bits above quotient
  localparam int CW   = (HW > DW) ? HW : DW;        // compare width
  localparam int CNTW = $clog2(DATA_WIDTH + 2);

  localparam logic [DW:0]   LIM_POS = {2'b00, {(DW-1){1'b1}}};
  localparam logic [DW:0]   LIM_NEG = {2'b01, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_NEG = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_NUM  = 7'b0000010,
    S_SUM  = 7'b0000100,
    S_ABS  = 7'b0001000,
    S_CHK  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  // Emit state, apart from the main state: E_WAIT holds a finished word for the output register
  typedef enum logic [1:0] {
    E_NONE = 2'b01,
    E_WAIT = 2'b10
  } emit_e;

  // Control state
  state_e                  state_q, state_d;
  emit_e                   emit_q, emit_d;
  job_mask_t               pending_q, pending_d;
  logic [1:0]              fill_q, fill_d;
  logic                    discard_q, discard_d;
  logic signed [DW-1:0]    wx0_q, wx1_q, wx2_q, wx0_d, wx1_d, wx2_d;
  logic signed [DW-1:0]    wy0_q, wy1_q, wy2_q, wy0_d, wy1_d, wy2_d;
  logic                    out_valid_q, out_valid_d;
  logic [CNTW-1:0]         cnt_q, cnt_d;

  // Datapath registers
  logic signed [NW-1:0]    a_q, a_d, b_q, b_d, num_q, num_d;
  logic                    sub_q, sub_d;
  logic [DW-1:0]           span_q, span_d;
  logic                    neg_q, neg_d;
  logic [NW-1:0]           mag_q, mag_d;
  logic [DW-1:0]           rem_q, rem_d;
  logic [DW:0]             quo_q, quo_d;
  logic [DW-1:0]           res_slope_q, res_slope_d;
  status_t                 res_status_q, res_status_d;
  logic                    res_fin_q, res_fin_d;
  logic [DW-1:0]           out_slope_q, out_slope_d;
  status_t                 out_status_q, out_status_d;
  logic                    out_fin_q, out_fin_d;

  // Combinational helpers
  logic                    accept;
  logic                    unordered;
  logic [1:0]              fill_inc;
  job_mask_t               cur_job;
  logic signed [NW-1:0]    y0e, y1e, y2e;
  logic signed [DW:0]      span_full;
  logic [MTW-1:0]          dvd;
  logic [HW-1:0]           h_w;
  logic [CW-1:0]           h_ext, d_ext;
  logic [DW:0]             trial, trial_diff, lim;
  logic                    ge;
  logic                    out_free;

  assign in_ready_o     = (state_q == S_IDLE) && (emit_q == E_NONE);
  assign accept         = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign slope_o        = out_slope_q;
  assign status_o       = out_status_q;
  assign final_result_o = out_fin_q;
  assign out_free       = !out_valid_q || out_ready_i;

  // Lowest pending job is served first
  always_comb begin
    if (pending_q[JOB_FIRST]) begin
      cur_job = job_mask_t'(1 << JOB_FIRST);
    end else if (pending_q[JOB_CENTRAL]) begin
      cur_job = job_mask_t'(1 << JOB_CENTRAL);
    end else begin
      cur_job = job_mask_t'(1 << JOB_END);
    end
  end

  assign unordered = (fill_q != 2'd0) && (sample_x_i < wx2_q);
  assign fill_inc  = (fill_q == 2'd3) ? 2'd3 : fill_q + 2'd1;

  assign y0e       = {{3{wy0_q[DW-1]}}, wy0_q};
  assign y1e       = {{3{wy1_q[DW-1]}}, wy1_q};
  assign y2e       = {{3{wy2_q[DW-1]}}, wy2_q};
  assign span_full = {wx2_q[DW-1], wx2_q} - {wx0_q[DW-1], wx0_q};

  // Scaled dividend: bits above the quotient window and the serial part
  assign dvd   = MTW'(mag_q) << FRAC_BITS;
  assign h_w   = dvd[MTW-1:DW+1];
  assign h_ext = CW'(h_w);
  assign d_ext = CW'(span_q);

  // One restoring step per cycle
  assign trial      = {rem_q, quo_q[DW]};
  assign trial_diff = trial - {1'b0, span_q};
  assign ge         = (trial >= {1'b0, span_q});
  assign lim        = neg_q ? LIM_NEG : LIM_POS;

  // Next-state logic
  always_comb begin
    state_d      = state_q;
    emit_d       = emit_q;
    pending_d    = pending_q;
    fill_d       = fill_q;
    discard_d    = discard_q;
    wx0_d        = wx0_q;
    wx1_d        = wx1_q;
    wx2_d        = wx2_q;
    wy0_d        = wy0_q;
    wy1_d        = wy1_q;
    wy2_d        = wy2_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cnt_d        = cnt_q;
    a_d          = a_q;
    b_d          = b_q;
    sub_d        = sub_q;
    num_d        = num_q;
    span_d       = span_q;
    neg_d        = neg_q;
    mag_d        = mag_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    res_slope_d  = res_slope_q;
    res_status_d = res_status_q;
    res_fin_d    = res_fin_q;
    out_slope_d  = out_slope_q;
    out_status_d = out_status_q;
    out_fin_d    = out_fin_q;

    // Hand a finished word to the output register
    if (emit_q == E_WAIT && out_free) begin
      out_valid_d  = 1'b1;
      out_slope_d  = res_slope_q;
      out_status_d = res_status_q;
      out_fin_d    = res_fin_q;
      pending_d    = pending_q & ~cur_job;
      emit_d       = E_NONE;
      state_d      = (pending_d != '0) ? S_NUM : S_IDLE;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (discard_q) begin
            // Dropping the tail of a bad run
            if (run_end_i) begin
              discard_d = 1'b0;
              fill_d    = 2'd0;
            end
          end else if (unordered) begin
            res_slope_d  = '0;
            res_status_d = ST_UNORDERED;
            res_fin_d    = 1'b1;
            pending_d    = '0;
            fill_d       = 2'd0;
            discard_d    = !run_end_i;
            emit_d       = E_WAIT;
          end else begin
            wx0_d = wx1_q;
            wx1_d = wx2_q;
            wx2_d = sample_x_i;
            wy0_d = wy1_q;
            wy1_d = wy2_q;
            wy2_d = sample_y_i;
            if (fill_inc != 2'd3) begin
              if (run_end_i) begin
                res_slope_d  = '0;
                res_status_d = ST_SHORT;
                res_fin_d    = 1'b1;
                pending_d    = '0;
                fill_d       = 2'd0;
                emit_d       = E_WAIT;
              end else begin
                fill_d = fill_inc;
              end
            end else begin
              pending_d              = '0;
              pending_d[JOB_FIRST]   = (fill_q == 2'd2);
              pending_d[JOB_CENTRAL] = 1'b1;
              pending_d[JOB_END]     = run_end_i;
              fill_d                 = run_end_i ? 2'd0 : 2'd3;
              state_d                = S_NUM;
            end
          end
        end
      end

      // Partial terms of the numerator, and the spacing
      S_NUM: begin
        span_d = span_full[DW-1:0];
        if (cur_job[JOB_FIRST]) begin
          a_d   = (y1e <<< 2) - y2e;
          b_d   = y0e + (y0e <<< 1);
          sub_d = 1'b1;
        end else if (cur_job[JOB_CENTRAL]) begin
          a_d   = y2e - y0e;
          b_d   = '0;
          sub_d = 1'b0;
        end else begin
          a_d   = y0e - (y1e <<< 2);
          b_d   = y2e + (y2e <<< 1);
          sub_d = 1'b0;
        end
        state_d = S_SUM;
      end

      S_SUM: begin
        num_d   = sub_q ? (a_q - b_q) : (a_q + b_q);
        state_d = S_ABS;
      end

      // Sign and magnitude
      S_ABS: begin
        neg_d   = num_q[NW-1];
        mag_d   = num_q[NW-1] ? (~num_q + 1'b1) : num_q;
        state_d = S_CHK;
      end

      // Early saturation: zero spacing, or quotient too wide
      S_CHK: begin
        res_fin_d = cur_job[JOB_END];
        if (span_q == '0 && mag_q == '0) begin
          res_slope_d  = '0;
          res_status_d = ST_SAT;
          emit_d       = E_WAIT;
          state_d      = S_FIN;
        end else if (h_ext >= d_ext) begin
          res_slope_d  = neg_q ? SAT_NEG : SAT_POS;
          res_status_d = ST_SAT;
          emit_d       = E_WAIT;
          state_d      = S_FIN;
        end else begin
          rem_d   = h_ext[DW-1:0];
          quo_d   = dvd[DW:0];
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end

      // One quotient bit per cycle
      S_DIV: begin
        rem_d = ge ? trial_diff[DW-1:0] : trial[DW-1:0];
        quo_d = {quo_q[DW-1:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNTW'(DATA_WIDTH)) begin
          state_d = S_FIN;
        end
      end

      // Range limit and sign; then wait for the output register
      S_FIN: begin
        if (emit_q == E_NONE && state_d == S_FIN) begin
          if (quo_q > lim) begin
            res_slope_d  = neg_q ? SAT_NEG : SAT_POS;
            res_status_d = ST_SAT;
          end else begin
            res_slope_d  = neg_q ? (~quo_q[DW-1:0] + 1'b1) : quo_q[DW-1:0];
            res_status_d = ST_OK;
          end
          emit_d = E_WAIT;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      emit_q      <= E_NONE;
      pending_q   <= '0;
      fill_q      <= 2'd0;
      discard_q   <= 1'b0;
      wx0_q       <= '0;
      wx1_q       <= '0;
      wx2_q       <= '0;
      wy0_q       <= '0;
      wy1_q       <= '0;
      wy2_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      emit_q      <= emit_d;
      pending_q   <= pending_d;
      fill_q      <= fill_d;
      discard_q   <= discard_d;
      wx0_q       <= wx0_d;
      wx1_q       <= wx1_d;
      wx2_q       <= wx2_d;
      wy0_q       <= wy0_d;
      wy1_q       <= wy1_d;
      wy2_q       <= wy2_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    sub_q        <= sub_d;
    num_q        <= num_d;
    span_q       <= span_d;
    neg_q        <= neg_d;
    mag_q        <= mag_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    res_slope_q  <= res_slope_d;
    res_status_q <= res_status_d;
    res_fin_q    <= res_fin_d;
    out_slope_q  <= out_slope_d;
    out_status_q <= out_status_d;
    out_fin_q    <= out_fin_d;
  end

endmodule
